/* rtl/core/credit_bound_epoch_tuner_core_defines.svh */
// assertion macros used by the tuner checker file
`ifndef CREDIT_BOUND_EPOCH_TUNER_CORE_DEFINES_SVH
`define CREDIT_BOUND_EPOCH_TUNER_CORE_DEFINES_SVH

// property that must hold in every cycle out of reset
`define CBET_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cbet check failed");

// consequent must hold in the cycle after the antecedent
`define CBET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbet check failed");

`endif

/* rtl/core/cbet_pkg.sv */
// shared widths, constants, register indexes and types of the credit tuner
package cbet_pkg;

  localparam int ACK_W     = 32;
  localparam int ELAPSED_W = 48;
  localparam int PROD_W    = ACK_W + 32;
  localparam int BOUND_W   = 9;
  localparam int DELTA_W   = 10;
  localparam int EPOCH_W   = 16;
  localparam int WEIGHT_W  = 16;
  localparam int WPROD_W   = ACK_W + WEIGHT_W;
  localparam int WCOUNT_W  = WPROD_W - 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [BOUND_W-1:0] UNLIMITED_CREDIT = 9'd256;

  localparam logic [8:0]  RST_START_BOUND      = 9'd32;
  localparam logic [8:0]  RST_BOUND_STEP       = 9'd8;
  localparam logic [7:0]  RST_BOUND_LIMIT      = 8'd128;
  localparam logic [15:0] RST_HOLD_EPOCHS      = 16'd100;
  localparam logic [31:0] RST_NOMINAL_CYCLES   = 32'd1000000;
  localparam logic [15:0] RST_UNLIMITED_WEIGHT = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BOUND      = 3'd0,
    CFG_BOUND_STEP       = 3'd1,
    CFG_BOUND_LIMIT      = 3'd2,
    CFG_HOLD_EPOCHS      = 3'd3,
    CFG_NOMINAL_CYCLES   = 3'd4,
    CFG_UNLIMITED_WEIGHT = 3'd5
  } cfg_idx_t;

  // scaler request and response
  typedef struct packed {
    logic                 start;
    logic [ACK_W-1:0]     ack;
    logic [31:0]          sample;
    logic [ELAPSED_W-1:0] elapsed;
  } scale_req_t;

  typedef struct packed {
    logic             done;
    logic [ACK_W-1:0] quot;
  } scale_rsp_t;

endpackage

/* rtl/core/cbet_stream_if.sv */
// valid/ready channel interfaces of the credit tuner
interface cbet_sample_if import cbet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACK_W-1:0]     ack_count;
  logic [ELAPSED_W-1:0] elapsed_cycles;

  modport source (output valid, output ack_count, output elapsed_cycles, input ready);
  modport sink (input valid, input ack_count, input elapsed_cycles, output ready);
endinterface

interface cbet_result_if import cbet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] credit_adj;
  logic [BOUND_W-1:0]        credit_cap;
  logic                      in_training;
  logic [ACK_W-1:0]          scaled_count;

  modport source (output valid, output credit_adj, output credit_cap,
                  output in_training, output scaled_count, input ready);
  modport sink (input valid, input credit_adj, input credit_cap,
                input in_training, input scaled_count, output ready);
endinterface

interface cbet_cfg_if import cbet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/cbet_scaler.sv */
// count scaler: one multiply then a bit-serial restoring divide
module cbet_scaler import cbet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } dstate_t;

  localparam int CNT_W = $clog2(PROD_W);

  dstate_t              state;
  logic [ACK_W-1:0]     op_a;
  logic [31:0]          op_b;
  logic [ELAPSED_W-1:0] dvsr;
  logic [PROD_W-1:0]    dvd;
  logic [ELAPSED_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic [ACK_W-1:0]     quot;

  logic [PROD_W-1:0]    prod;
  logic [ELAPSED_W:0]   trial;
  logic [ELAPSED_W:0]   diff;
  logic                 qbit;
  logic [PROD_W-1:0]    dvd_next;
  logic [ELAPSED_W-1:0] rem_next;
  logic                 finish;

  always_comb begin
    prod     = PROD_W'(op_a) * PROD_W'(op_b);
    trial    = {rem, dvd[PROD_W-1]};
    diff     = trial - {1'b0, dvsr};
    qbit     = ~diff[ELAPSED_W];
    rem_next = qbit ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
    dvd_next = {dvd[PROD_W-2:0], qbit};
    finish   = ((state == D_MUL) && (dvsr == '0)) ||
               ((state == D_DIV) && (cnt == CNT_W'(PROD_W - 1)));
  end

  // one-cycle completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (req.start) begin
            op_a  <= req.ack;
            op_b  <= req.sample;
            dvsr  <= req.elapsed;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          if (dvsr == '0) begin
            // zero elapsed takes the count unscaled
            quot  <= op_a;
            state <= D_IDLE;
          end else begin
            dvd   <= prod;
            rem   <= '0;
            cnt   <= '0;
            state <= D_DIV;
          end
        end
        D_DIV: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(PROD_W - 1)) begin
            // saturate quotients that overflow 32 bits
            quot  <= (dvd_next[PROD_W-1:ACK_W] != '0) ? '1 : dvd_next[ACK_W-1:0];
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* rtl/core/credit_bound_epoch_tuner_core.sv */
// top level of the credit bound epoch tuner
// One epoch summary (ack_count, elapsed_cycles) is taken on the sample channel and
// one result beat leaves on the result channel. The count is scaled to the nominal
// epoch by a single 32x32 multiply followed by a bit-serial restoring divider that
// retires one quotient bit per cycle. After the accepting edge come the multiply,
// 64 divide steps, quotient capture, weight multiply and the update that loads the
// result; with zero elapsed_cycles the divide is skipped. One item is worked on at
// a time; sample.ready is high only while the core is idle and out of reset. The
// core returns to idle on the edge that loads the result, so a new item is taken
// only once the last one has loaded its result. A finished result sits in an output
// register, so the next item can be accepted while it waits; only a result that
// finds that register still full holds the core in its update step. Configuration
// writes are taken whenever the core is out of reset (cfg.ready is high) and are
// meant to happen only while the core is idle; indexes past the register list are
// ignored.
module credit_bound_epoch_tuner_core import cbet_pkg::*; (
  input  logic clk,
  input  logic rst,
  cbet_sample_if.sink   sample,
  cbet_result_if.source result,
  cbet_cfg_if.sink      cfg
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_WGT  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  // configuration registers
  logic [8:0]  start_bound;
  logic [8:0]  bound_step;
  logic [7:0]  bound_limit;
  logic [15:0] hold_epochs;
  logic [31:0] nominal_cycles;
  logic [15:0] unlimited_weight;

  // tuner state
  state_t               state;
  logic [BOUND_W-1:0]   bound_now;
  logic                 started;
  logic                 training;
  logic [EPOCH_W-1:0]   exec_count;
  logic [ACK_W-1:0]     best_count;
  logic [BOUND_W-1:0]   best_bound;

  // per-item working registers
  logic [ACK_W-1:0]     scaled;
  logic [WCOUNT_W-1:0]  weighted;

  // result register
  logic                      res_valid;
  logic signed [DELTA_W-1:0] res_delta;
  logic [BOUND_W-1:0]        res_bound;
  logic                      res_training;
  logic [ACK_W-1:0]          res_scaled;

  scale_req_t sreq;
  scale_rsp_t srsp;

  // update decision, from the current state
  logic [WPROD_W-1:0]  wprod;
  logic [EPOCH_W-1:0]  ec;
  logic [DELTA_W-1:0]  room;
  logic                jump;
  logic [DELTA_W-1:0]  delta_next;
  logic [BOUND_W-1:0]  bound_next;
  logic                training_next;
  logic [EPOCH_W-1:0]  exec_next;
  logic [ACK_W-1:0]    best_count_next;
  logic [BOUND_W-1:0]  best_bound_next;
  logic                sample_beat;
  logic                load_result;

  assign sample_beat  = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready    = !rst;
  assign load_result  = (state == ST_UPD) && (!res_valid || result.ready);

  assign sreq.start   = sample_beat;
  assign sreq.ack     = sample.ack_count;
  assign sreq.sample  = nominal_cycles;
  assign sreq.elapsed = sample.elapsed_cycles;

  cbet_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  assign wprod = WPROD_W'(scaled) * WPROD_W'(unlimited_weight);

  always_comb begin
    ec              = exec_count + 1'b1;
    room            = DELTA_W'(UNLIMITED_CREDIT) - {1'b0, bound_now};
    // jump to unlimited at or past the maximum, or when one step would reach it
    jump            = (bound_now >= {1'b0, bound_limit}) || (bound_now > UNLIMITED_CREDIT) ||
                      (room <= {1'b0, bound_step});
    delta_next      = '0;
    bound_next      = bound_now;
    training_next   = training;
    exec_next       = exec_count;
    best_count_next = best_count;
    best_bound_next = best_bound;
    if (scaled != '0) begin
      if (!training) begin
        // execution: hold the bound, retrain after the epoch budget
        exec_next = ec;
        if (ec == hold_epochs) begin
          training_next   = 1'b1;
          best_count_next = '0;
          best_bound_next = '0;
          delta_next      = {1'b0, start_bound} - {1'b0, bound_now};
          bound_next      = start_bound;
          exec_next       = '0;
        end
      end else if (bound_now == UNLIMITED_CREDIT) begin
        // judge unlimited against the best finite bound seen
        if (!(WCOUNT_W'(best_count) < weighted) && (best_count != '0)) begin
          delta_next = {1'b0, best_bound} - {1'b0, bound_now};
          bound_next = best_bound;
        end
        training_next = 1'b0;
        exec_next     = '0;
      end else begin
        if (best_count < scaled) begin
          best_count_next = scaled;
          best_bound_next = bound_now;
        end
        if (jump) begin
          delta_next = DELTA_W'(UNLIMITED_CREDIT) - {1'b0, bound_now};
          bound_next = UNLIMITED_CREDIT;
        end else begin
          delta_next = {1'b0, bound_step};
          bound_next = bound_now + bound_step;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_bound      <= RST_START_BOUND;
      bound_step       <= RST_BOUND_STEP;
      bound_limit      <= RST_BOUND_LIMIT;
      hold_epochs      <= RST_HOLD_EPOCHS;
      nominal_cycles   <= RST_NOMINAL_CYCLES;
      unlimited_weight <= RST_UNLIMITED_WEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_START_BOUND:      start_bound      <= cfg.data[8:0];
        CFG_BOUND_STEP:       bound_step       <= cfg.data[8:0];
        CFG_BOUND_LIMIT:      bound_limit      <= cfg.data[7:0];
        CFG_HOLD_EPOCHS:      hold_epochs      <= cfg.data[15:0];
        CFG_NOMINAL_CYCLES:   nominal_cycles   <= cfg.data[31:0];
        CFG_UNLIMITED_WEIGHT: unlimited_weight <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and tuner state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bound_now  <= '0;
      started    <= 1'b0;
      training   <= 1'b1;
      exec_count <= '0;
      best_count <= '0;
      best_bound <= '0;
      res_valid  <= 1'b0;
    end else begin
      // a new result replaces one that leaves on the same edge
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_beat) begin
            // bound is taken from the register on the very first epoch
            if (!started) begin
              bound_now <= start_bound;
              started   <= 1'b1;
            end
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (srsp.done) begin
            scaled <= srsp.quot;
            state  <= ST_WGT;
          end
        end
        ST_WGT: begin
          // Q8.8 weight, fraction dropped
          weighted <= wprod[WPROD_W-1:8];
          state    <= ST_UPD;
        end
        ST_UPD: begin
          if (load_result) begin
            bound_now    <= bound_next;
            training     <= training_next;
            exec_count   <= exec_next;
            best_count   <= best_count_next;
            best_bound   <= best_bound_next;
            res_delta    <= delta_next;
            res_bound    <= bound_next;
            res_training <= training_next;
            res_scaled   <= scaled;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.credit_adj   = res_delta;
  assign result.credit_cap   = res_bound;
  assign result.in_training  = res_training;
  assign result.scaled_count = res_scaled;

endmodule

/* rtl/core/cbet_checker.sv */
// port-level checks of the credit tuner and their bind
`include "credit_bound_epoch_tuner_core_defines.svh"

module cbet_checker import cbet_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_valid,
  input logic                      s_ready,
  input logic                      r_valid,
  input logic                      r_ready,
  input logic signed [DELTA_W-1:0] r_delta,
  input logic [BOUND_W-1:0]        r_bound,
  input logic                      r_training,
  input logic [ACK_W-1:0]          r_scaled
);

  logic r_stall;

  assign r_stall = r_valid && !r_ready;

  // a stalled result beat stays offered
  `CBET_ASSERT_NEXT(a_res_hold, clk, rst, r_stall, r_valid)
  // and its payload holds
  `CBET_ASSERT_NEXT(a_res_stable, clk, rst, r_stall, $stable({r_delta, r_bound, r_training, r_scaled}))
  // an empty epoch never moves the credit
  `CBET_ASSERT(a_zero_delta, clk, rst, ((r_valid && (r_scaled == '0)) |-> (r_delta == '0)))
  // one item at a time: no new sample right after one is taken
  `CBET_ASSERT_NEXT(a_one_item, clk, rst, (!rst && s_valid && s_ready), !s_ready)

endmodule

bind credit_bound_epoch_tuner_core cbet_checker u_cbet_checker (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (sample.valid),
  .s_ready    (sample.ready),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .r_delta    (result.credit_adj),
  .r_bound    (result.credit_cap),
  .r_training (result.in_training),
  .r_scaled   (result.scaled_count)
);
